### design/socks5_handshake_parser_macros.svh
// Assertion macros for the SOCKS5 handshake parser core.
`ifndef SOCKS5_HANDSHAKE_PARSER_MACROS_SVH
`define SOCKS5_HANDSHAKE_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/shp_pkg.sv
// Types and constants for the SOCKS5 handshake parser.
package shp_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CountW    = 9;
  localparam int unsigned KindW     = 2;
  localparam int unsigned ReplyW    = 4;
  localparam int unsigned AtypW     = 3;
  localparam int unsigned AddrHalfW = 64;
  localparam int unsigned PortW     = 16;

  localparam logic [KindW-1:0] KIND_GREET  = 2'd0;
  localparam logic [KindW-1:0] KIND_DOMAIN = 2'd1;
  localparam logic [KindW-1:0] KIND_REQ    = 2'd2;
  localparam logic [KindW-1:0] KIND_ERR    = 2'd3;

  localparam logic [ReplyW-1:0] REP_OK      = 4'd0;
  localparam logic [ReplyW-1:0] REP_GENERAL = 4'd1;
  localparam logic [ReplyW-1:0] REP_CMD     = 4'd7;
  localparam logic [ReplyW-1:0] REP_ATYP    = 4'd8;

  localparam logic [ByteW-1:0] SOCKS_VER   = 8'h05;
  localparam logic [ByteW-1:0] CMD_CONNECT = 8'h01;
  localparam logic [ByteW-1:0] BYTE_ZERO   = 8'h00;
  localparam logic [ByteW-1:0] ATYP_IPV4   = 8'h01;
  localparam logic [ByteW-1:0] ATYP_DOMAIN = 8'h03;
  localparam logic [ByteW-1:0] ATYP_IPV6   = 8'h04;
  localparam logic [ByteW-1:0] METH_NOAUTH = 8'h00;
  localparam logic [ByteW-1:0] METH_NONE   = 8'hFF;

  localparam logic [AtypW-1:0] AT_NONE   = 3'd0;
  localparam logic [AtypW-1:0] AT_IPV4   = 3'd1;
  localparam logic [AtypW-1:0] AT_DOMAIN = 3'd3;
  localparam logic [AtypW-1:0] AT_IPV6   = 3'd4;

  localparam logic [ByteW-1:0] IPV4_LEN = 8'd4;
  localparam logic [ByteW-1:0] IPV6_LEN = 8'd16;

  typedef enum logic [13:0] {
    PH_G_VER   = 14'b00000000000001,
    PH_G_NMETH = 14'b00000000000010,
    PH_G_METH  = 14'b00000000000100,
    PH_R_VER   = 14'b00000000001000,
    PH_R_CMD   = 14'b00000000010000,
    PH_R_RSV   = 14'b00000000100000,
    PH_R_ATYP  = 14'b00000001000000,
    PH_R_ADDR  = 14'b00000010000000,
    PH_R_DLEN  = 14'b00000100000000,
    PH_R_DOM   = 14'b00001000000000,
    PH_R_PORTH = 14'b00010000000000,
    PH_R_PORTL = 14'b00100000000000,
    PH_DONE    = 14'b01000000000000,
    PH_DEAD    = 14'b10000000000000
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             restart;
  } item_t;

  typedef struct packed {
    logic [KindW-1:0]     result_kind;
    logic [ReplyW-1:0]    status_code;
    logic                 no_reply;
    logic [ByteW-1:0]     method;
    logic [AtypW-1:0]     address_type;
    logic [AddrHalfW-1:0] addr_high;
    logic [AddrHalfW-1:0] addr_low;
    logic [PortW-1:0]     port;
    logic [ByteW-1:0]     name_len;
    logic [ByteW-1:0]     domain_byte;
    logic [CountW-1:0]    consumed;
  } result_t;

endpackage

### design/shp_in_if.sv
// Request byte channel: valid/ready handshake with one client byte per item.
interface shp_in_if;
  logic                      valid;
  logic                      ready;
  logic [shp_pkg::ByteW-1:0] data_byte;
  logic                      restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

### design/shp_out_if.sv
// Parser result channel: valid/ready handshake with one result per item.
interface shp_out_if;
  logic                          valid;
  logic                          ready;
  logic [shp_pkg::KindW-1:0]     result_kind;
  logic [shp_pkg::ReplyW-1:0]    status_code;
  logic                          no_reply;
  logic [shp_pkg::ByteW-1:0]     method;
  logic [shp_pkg::AtypW-1:0]     address_type;
  logic [shp_pkg::AddrHalfW-1:0] addr_high;
  logic [shp_pkg::AddrHalfW-1:0] addr_low;
  logic [shp_pkg::PortW-1:0]     port;
  logic [shp_pkg::ByteW-1:0]     name_len;
  logic [shp_pkg::ByteW-1:0]     domain_byte;
  logic [shp_pkg::CountW-1:0]    consumed;

  modport source (output valid, output result_kind, output status_code, output no_reply,
                  output method, output address_type, output addr_high, output addr_low,
                  output port, output name_len, output domain_byte, output consumed,
                  input ready);
  modport sink   (input valid, input result_kind, input status_code, input no_reply,
                  input method, input address_type, input addr_high, input addr_low,
                  input port, input name_len, input domain_byte, input consumed,
                  output ready);
endinterface

### design/shp_in_stage.sv
// Input register stage holding one accepted request byte.
module shp_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  shp_pkg::item_t  in_item,
  input  logic            advance,
  output logic            item_valid,
  output shp_pkg::item_t  item
);

  logic           valid_r;
  shp_pkg::item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

### design/shp_core.sv
// Parser state and per-byte decode of the greeting and connect request.
`include "socks5_handshake_parser_macros.svh"

module shp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  shp_pkg::item_t    item,
  output logic              res_valid,
  output shp_pkg::result_t  res
);

  shp_pkg::phase_t                   phase_r, phase_nxt;
  logic [shp_pkg::CountW-1:0]        byte_count_r, byte_count_nxt;
  logic [shp_pkg::ByteW-1:0]         remaining_r, remaining_nxt;
  logic                              saw_no_auth_r, saw_no_auth_nxt;
  logic [shp_pkg::AtypW-1:0]         kept_atyp_r, kept_atyp_nxt;
  logic [2*shp_pkg::AddrHalfW-1:0]   addr_r, addr_nxt;
  logic [shp_pkg::ByteW-1:0]         port_hi_r, port_hi_nxt;
  logic [shp_pkg::ByteW-1:0]         kept_dlen_r, kept_dlen_nxt;

  always_comb begin
    logic [shp_pkg::ByteW-1:0]   b;
    shp_pkg::phase_t             ph;
    logic [shp_pkg::CountW-1:0]  bc_inc;
    logic [shp_pkg::ByteW-1:0]   rem_dec;

    b = item.data_byte;

    // restart rewinds all state before this byte is parsed
    if (item.restart) begin
      ph              = shp_pkg::PH_G_VER;
      byte_count_nxt  = '0;
      remaining_nxt   = '0;
      saw_no_auth_nxt = 1'b0;
      kept_atyp_nxt   = shp_pkg::AT_NONE;
      addr_nxt        = '0;
      port_hi_nxt     = '0;
      kept_dlen_nxt   = '0;
    end else begin
      ph              = phase_r;
      byte_count_nxt  = byte_count_r;
      remaining_nxt   = remaining_r;
      saw_no_auth_nxt = saw_no_auth_r;
      kept_atyp_nxt   = kept_atyp_r;
      addr_nxt        = addr_r;
      port_hi_nxt     = port_hi_r;
      kept_dlen_nxt   = kept_dlen_r;
    end

    phase_nxt = ph;
    bc_inc    = byte_count_nxt + 9'd1;
    rem_dec   = remaining_nxt - 8'd1;
    res_valid = 1'b0;
    res       = '0;

    if (ph != shp_pkg::PH_DONE && ph != shp_pkg::PH_DEAD) begin
      byte_count_nxt = bc_inc;
    end

    unique case (ph)
      shp_pkg::PH_G_VER: begin
        if (b != shp_pkg::SOCKS_VER) begin
          res_valid       = 1'b1;
          res.result_kind = shp_pkg::KIND_ERR;
          res.status_code = shp_pkg::REP_GENERAL;
          res.no_reply    = 1'b1;
          phase_nxt       = shp_pkg::PH_DEAD;
        end else begin
          phase_nxt = shp_pkg::PH_G_NMETH;
        end
      end
      shp_pkg::PH_G_NMETH: begin
        if (b == shp_pkg::BYTE_ZERO) begin
          res_valid       = 1'b1;
          res.result_kind = shp_pkg::KIND_ERR;
          res.status_code = shp_pkg::REP_GENERAL;
          res.no_reply    = 1'b1;
          phase_nxt       = shp_pkg::PH_DEAD;
        end else begin
          remaining_nxt   = b;
          saw_no_auth_nxt = 1'b0;
          phase_nxt       = shp_pkg::PH_G_METH;
        end
      end
      shp_pkg::PH_G_METH: begin
        saw_no_auth_nxt = saw_no_auth_nxt || (b == shp_pkg::METH_NOAUTH);
        remaining_nxt   = rem_dec;
        if (rem_dec == '0) begin
          res_valid       = 1'b1;
          res.result_kind = shp_pkg::KIND_GREET;
          res.method      = saw_no_auth_nxt ? shp_pkg::METH_NOAUTH : shp_pkg::METH_NONE;
          res.consumed    = bc_inc;
          byte_count_nxt  = '0;
          phase_nxt       = shp_pkg::PH_R_VER;
        end
      end
      shp_pkg::PH_R_VER: begin
        if (b != shp_pkg::SOCKS_VER) begin
          res_valid       = 1'b1;
          res.result_kind = shp_pkg::KIND_ERR;
          res.status_code = shp_pkg::REP_GENERAL;
          res.no_reply    = 1'b1;
          phase_nxt       = shp_pkg::PH_DEAD;
        end else begin
          phase_nxt = shp_pkg::PH_R_CMD;
        end
      end
      shp_pkg::PH_R_CMD: begin
        if (b != shp_pkg::CMD_CONNECT) begin
          res_valid       = 1'b1;
          res.result_kind = shp_pkg::KIND_ERR;
          res.status_code = shp_pkg::REP_CMD;
          phase_nxt       = shp_pkg::PH_DEAD;
        end else begin
          phase_nxt = shp_pkg::PH_R_RSV;
        end
      end
      shp_pkg::PH_R_RSV: begin
        if (b != shp_pkg::BYTE_ZERO) begin
          res_valid       = 1'b1;
          res.result_kind = shp_pkg::KIND_ERR;
          res.status_code = shp_pkg::REP_GENERAL;
          phase_nxt       = shp_pkg::PH_DEAD;
        end else begin
          phase_nxt = shp_pkg::PH_R_ATYP;
        end
      end
      shp_pkg::PH_R_ATYP: begin
        addr_nxt      = '0;
        port_hi_nxt   = '0;
        kept_dlen_nxt = '0;
        if (b == shp_pkg::ATYP_IPV4) begin
          kept_atyp_nxt = shp_pkg::AT_IPV4;
          remaining_nxt = shp_pkg::IPV4_LEN;
          phase_nxt     = shp_pkg::PH_R_ADDR;
        end else if (b == shp_pkg::ATYP_DOMAIN) begin
          kept_atyp_nxt = shp_pkg::AT_DOMAIN;
          phase_nxt     = shp_pkg::PH_R_DLEN;
        end else if (b == shp_pkg::ATYP_IPV6) begin
          kept_atyp_nxt = shp_pkg::AT_IPV6;
          remaining_nxt = shp_pkg::IPV6_LEN;
          phase_nxt     = shp_pkg::PH_R_ADDR;
        end else begin
          res_valid       = 1'b1;
          res.result_kind = shp_pkg::KIND_ERR;
          res.status_code = shp_pkg::REP_ATYP;
          phase_nxt       = shp_pkg::PH_DEAD;
        end
      end
      shp_pkg::PH_R_ADDR: begin
        addr_nxt      = {addr_nxt[2*shp_pkg::AddrHalfW-shp_pkg::ByteW-1:0], b};
        remaining_nxt = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = shp_pkg::PH_R_PORTH;
        end
      end
      shp_pkg::PH_R_DLEN: begin
        kept_dlen_nxt = b;
        remaining_nxt = b;
        phase_nxt     = (b == '0) ? shp_pkg::PH_R_PORTH : shp_pkg::PH_R_DOM;
      end
      shp_pkg::PH_R_DOM: begin
        res_valid        = 1'b1;
        res.result_kind  = shp_pkg::KIND_DOMAIN;
        res.address_type = shp_pkg::AT_DOMAIN;
        res.name_len     = kept_dlen_nxt;
        res.domain_byte  = b;
        remaining_nxt    = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = shp_pkg::PH_R_PORTH;
        end
      end
      shp_pkg::PH_R_PORTH: begin
        port_hi_nxt = b;
        phase_nxt   = shp_pkg::PH_R_PORTL;
      end
      shp_pkg::PH_R_PORTL: begin
        res_valid        = 1'b1;
        res.result_kind  = shp_pkg::KIND_REQ;
        res.address_type = kept_atyp_nxt;
        res.addr_high    = addr_nxt[2*shp_pkg::AddrHalfW-1:shp_pkg::AddrHalfW];
        res.addr_low     = addr_nxt[shp_pkg::AddrHalfW-1:0];
        res.port         = {port_hi_nxt, b};
        res.name_len     = (kept_atyp_nxt == shp_pkg::AT_DOMAIN) ? kept_dlen_nxt : '0;
        res.consumed     = bc_inc;
        phase_nxt        = shp_pkg::PH_DONE;
      end
      shp_pkg::PH_DONE, shp_pkg::PH_DEAD: begin
        phase_nxt = ph;
      end
      default: begin
        phase_nxt = shp_pkg::PH_DEAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= shp_pkg::PH_G_VER;
      byte_count_r  <= '0;
      remaining_r   <= '0;
      saw_no_auth_r <= 1'b0;
      kept_atyp_r   <= shp_pkg::AT_NONE;
      addr_r        <= '0;
      port_hi_r     <= '0;
      kept_dlen_r   <= '0;
    end else if (take) begin
      phase_r       <= phase_nxt;
      byte_count_r  <= byte_count_nxt;
      remaining_r   <= remaining_nxt;
      saw_no_auth_r <= saw_no_auth_nxt;
      kept_atyp_r   <= kept_atyp_nxt;
      addr_r        <= addr_nxt;
      port_hi_r     <= port_hi_nxt;
      kept_dlen_r   <= kept_dlen_nxt;
    end
  end

  `SHP_ASSERT_NEXT(a_err_kills, clk, rst_n,
    take && res_valid && res.result_kind == shp_pkg::KIND_ERR,
    phase_r == shp_pkg::PH_DEAD, "error did not end the request")
  `SHP_ASSERT_NEXT(a_greet_clears_count, clk, rst_n,
    take && res_valid && res.result_kind == shp_pkg::KIND_GREET,
    byte_count_r == '0 && phase_r == shp_pkg::PH_R_VER, "greeting end did not rewind count")
  `SHP_ASSERT_NOW(a_idle_silent, clk, rst_n,
    !item.restart && (phase_r == shp_pkg::PH_DONE || phase_r == shp_pkg::PH_DEAD),
    !res_valid, "result produced after request end")
  `SHP_ASSERT_NOW(a_domain_atyp, clk, rst_n,
    res_valid && res.result_kind == shp_pkg::KIND_DOMAIN,
    res.address_type == shp_pkg::AT_DOMAIN && res.name_len != '0,
    "domain byte with bad address info")

endmodule

### design/shp_out_stage.sv
// Result register stage with valid/ready output handshake.
module shp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic              res_valid,
  input  shp_pkg::result_t  res,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_ready,
  output shp_pkg::result_t  out_res
);

  logic             valid_r;
  shp_pkg::result_t res_r;

  assign advance   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= take && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      res_r <= res;
    end
  end

endmodule

### design/socks5_handshake_parser.sv
// SOCKS5 client handshake parser top level: greeting and connect request, one byte per item.
// Throughput: one byte per cycle sustained while the result side keeps taking results.
// An accepted byte is held in the input register, decoded by the core and its result registered.
// A stalled result holds the parse stage; the input register can still take a byte if it is empty.
// Synchronous active-low reset returns the parser to the greeting version byte.
module socks5_handshake_parser (
  input  logic       clk,
  input  logic       rst_n,
  shp_in_if.sink     in_ch,
  shp_out_if.source  out_ch
);

  shp_pkg::item_t   in_item;
  shp_pkg::item_t   item;
  logic             item_valid;
  logic             advance;
  logic             take;
  logic             res_valid;
  shp_pkg::result_t res;
  shp_pkg::result_t out_res;

  assign in_item.data_byte = in_ch.data_byte;
  assign in_item.restart   = in_ch.restart;
  assign take              = item_valid && advance;

  shp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  shp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  shp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.result_kind  = out_res.result_kind;
  assign out_ch.status_code  = out_res.status_code;
  assign out_ch.no_reply     = out_res.no_reply;
  assign out_ch.method       = out_res.method;
  assign out_ch.address_type = out_res.address_type;
  assign out_ch.addr_high    = out_res.addr_high;
  assign out_ch.addr_low     = out_res.addr_low;
  assign out_ch.port         = out_res.port;
  assign out_ch.name_len     = out_res.name_len;
  assign out_ch.domain_byte  = out_res.domain_byte;
  assign out_ch.consumed     = out_res.consumed;

endmodule

### sim/socks5_handshake_parser_tb.sv
// Self-checking testbench for the SOCKS5 handshake parser: directed and random byte streams.
module socks5_handshake_parser_tb;
  import shp_pkg::*;

  typedef logic [ByteW-1:0] byte_seq_t[$];

  logic clk = 1'b0;
  logic rst_n;

  shp_in_if  in_ch();
  shp_out_if out_ch();

  socks5_handshake_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  item_t   pending_bytes[$];
  result_t expected_results[$];
  int      mismatches = 0;

  // shadow parser state
  phase_t               parse_phase;
  logic [CountW-1:0]    msg_bytes;
  logic [ByteW-1:0]     bytes_left;
  logic                 offered_no_auth;
  logic [AtypW-1:0]     req_atyp;
  logic [AddrHalfW-1:0] addr_hi;
  logic [AddrHalfW-1:0] addr_lo;
  logic [PortW-1:0]     req_port;
  logic [ByteW-1:0]     dom_len;

  logic calm;
  int   calm_timer;

  task automatic restart_parse();
    parse_phase     = PH_G_VER;
    msg_bytes       = '0;
    bytes_left      = '0;
    offered_no_auth = 1'b0;
    req_atyp        = AT_NONE;
    addr_hi         = '0;
    addr_lo         = '0;
    req_port        = '0;
    dom_len         = '0;
  endtask

  task automatic flag_error(logic [ReplyW-1:0] code, logic silent);
    result_t r;
    r             = '0;
    r.result_kind = KIND_ERR;
    r.status_code = code;
    r.no_reply    = silent;
    expected_results.push_back(r);
    parse_phase = PH_DEAD;
  endtask

  task automatic parse_byte(item_t it);
    result_t          r;
    logic [ByteW-1:0] b;
    r = '0;
    b = it.data_byte;
    if (it.restart) restart_parse();
    if (parse_phase == PH_DONE || parse_phase == PH_DEAD) return;
    msg_bytes = msg_bytes + 9'd1;
    case (parse_phase)
      PH_G_VER: begin
        if (b != SOCKS_VER) flag_error(REP_GENERAL, 1'b1);
        else parse_phase = PH_G_NMETH;
      end
      PH_G_NMETH: begin
        if (b == BYTE_ZERO) begin
          flag_error(REP_GENERAL, 1'b1);
        end else begin
          bytes_left      = b;
          offered_no_auth = 1'b0;
          parse_phase     = PH_G_METH;
        end
      end
      PH_G_METH: begin
        if (b == METH_NOAUTH) offered_no_auth = 1'b1;
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == '0) begin
          r.result_kind = KIND_GREET;
          r.method      = offered_no_auth ? METH_NOAUTH : METH_NONE;
          r.consumed    = msg_bytes;
          expected_results.push_back(r);
          msg_bytes   = '0;
          parse_phase = PH_R_VER;
        end
      end
      PH_R_VER: begin
        if (b != SOCKS_VER) flag_error(REP_GENERAL, 1'b1);
        else parse_phase = PH_R_CMD;
      end
      PH_R_CMD: begin
        if (b != CMD_CONNECT) flag_error(REP_CMD, 1'b0);
        else parse_phase = PH_R_RSV;
      end
      PH_R_RSV: begin
        if (b != BYTE_ZERO) flag_error(REP_GENERAL, 1'b0);
        else parse_phase = PH_R_ATYP;
      end
      PH_R_ATYP: begin
        addr_hi  = '0;
        addr_lo  = '0;
        req_port = '0;
        dom_len  = '0;
        if (b == ATYP_IPV4) begin
          req_atyp    = AT_IPV4;
          bytes_left  = IPV4_LEN;
          parse_phase = PH_R_ADDR;
        end else if (b == ATYP_DOMAIN) begin
          req_atyp    = AT_DOMAIN;
          parse_phase = PH_R_DLEN;
        end else if (b == ATYP_IPV6) begin
          req_atyp    = AT_IPV6;
          bytes_left  = IPV6_LEN;
          parse_phase = PH_R_ADDR;
        end else begin
          flag_error(REP_ATYP, 1'b0);
        end
      end
      PH_R_ADDR: begin
        {addr_hi, addr_lo} = {addr_hi[AddrHalfW-9:0], addr_lo, b};
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == '0) parse_phase = PH_R_PORTH;
      end
      PH_R_DLEN: begin
        dom_len     = b;
        bytes_left  = b;
        parse_phase = (b == BYTE_ZERO) ? PH_R_PORTH : PH_R_DOM;
      end
      PH_R_DOM: begin
        r.result_kind  = KIND_DOMAIN;
        r.address_type = AT_DOMAIN;
        r.name_len     = dom_len;
        r.domain_byte  = b;
        expected_results.push_back(r);
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == '0) parse_phase = PH_R_PORTH;
      end
      PH_R_PORTH: begin
        req_port    = {8'h00, b};
        parse_phase = PH_R_PORTL;
      end
      PH_R_PORTL: begin
        req_port       = {req_port[7:0], b};
        r.result_kind  = KIND_REQ;
        r.address_type = req_atyp;
        r.addr_high    = addr_hi;
        r.addr_low     = addr_lo;
        r.port         = req_port;
        r.name_len     = (req_atyp == AT_DOMAIN) ? dom_len : '0;
        r.consumed     = msg_bytes;
        expected_results.push_back(r);
        parse_phase = PH_DONE;
      end
      default: ;
    endcase
  endtask

  function automatic int idle_span();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send(byte_seq_t seq);
    item_t it;
    foreach (seq[i]) begin
      it.data_byte = seq[i];
      it.restart   = (i == 0);
      pending_bytes.push_back(it);
    end
  endtask

  function automatic byte_seq_t build_handshake();
    byte_seq_t s;
    int        n_meth;
    int        n_dom;
    int        no_auth_at;
    n_meth     = ($urandom_range(0, 24) == 0) ? 255 : $urandom_range(1, 6);
    no_auth_at = $urandom_range(0, 1) ? $urandom_range(0, n_meth - 1) : -1;
    s.push_back(SOCKS_VER);
    s.push_back(8'(n_meth));
    for (int i = 0; i < n_meth; i++)
      s.push_back((i == no_auth_at) ? METH_NOAUTH : 8'($urandom_range(1, 255)));
    s.push_back(SOCKS_VER);
    s.push_back(CMD_CONNECT);
    s.push_back(BYTE_ZERO);
    case ($urandom_range(0, 2))
      0: begin
        s.push_back(ATYP_IPV4);
        repeat (IPV4_LEN) s.push_back(8'($urandom));
      end
      1: begin
        n_dom = ($urandom_range(0, 24) == 0) ? 255 : $urandom_range(0, 12);
        s.push_back(ATYP_DOMAIN);
        s.push_back(8'(n_dom));
        repeat (n_dom) s.push_back(8'($urandom));
      end
      default: begin
        s.push_back(ATYP_IPV6);
        repeat (IPV6_LEN) s.push_back(8'($urandom));
      end
    endcase
    repeat (2) s.push_back(8'($urandom));
    return s;
  endfunction

  always @(posedge clk) begin
    if (calm_timer == 0) begin
      calm       <= ($urandom_range(0, 3) == 0);
      calm_timer = $urandom_range(50, 300);
    end else begin
      calm_timer--;
    end
  end

  // request byte driver
  item_t taken_item;
  item_t next_item;
  int    in_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken_item.data_byte = in_ch.data_byte;
        taken_item.restart   = in_ch.restart;
        parse_byte(taken_item);
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_item = pending_bytes.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.data_byte <= next_item.data_byte;
          in_ch.restart   <= next_item.restart;
          in_gap = idle_span();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // result monitor
  result_t want;
  int      out_stall;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result expected none got kind %0h", $time, out_ch.result_kind);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("result_kind", 64'(want.result_kind), 64'(out_ch.result_kind));
          compare_field("status_code", 64'(want.status_code), 64'(out_ch.status_code));
          compare_field("no_reply", 64'(want.no_reply), 64'(out_ch.no_reply));
          compare_field("method", 64'(want.method), 64'(out_ch.method));
          compare_field("address_type", 64'(want.address_type), 64'(out_ch.address_type));
          compare_field("addr_high", want.addr_high, out_ch.addr_high);
          compare_field("addr_low", want.addr_low, out_ch.addr_low);
          compare_field("port", 64'(want.port), 64'(out_ch.port));
          compare_field("name_len", 64'(want.name_len), 64'(out_ch.name_len));
          compare_field("domain_byte", 64'(want.domain_byte), 64'(out_ch.domain_byte));
          compare_field("consumed", 64'(want.consumed), 64'(out_ch.consumed));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_stall = idle_span();
      end
    end
  end

  initial begin
    byte_seq_t seq;
    int        directed;
    int        pick;
    int        cut;
    item_t     it;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.restart   = 1'b0;
    out_ch.ready    = 1'b0;
    calm            = 1'b0;
    calm_timer      = 0;
    rst_n           = 1'b0;
    restart_parse();

    // bad greeting version, then a byte that must be ignored
    seq = '{8'hFF, SOCKS_VER};
    send(seq);
    // zero method count
    seq = '{SOCKS_VER, BYTE_ZERO};
    send(seq);
    // no-auth offered, bad request version
    seq = '{SOCKS_VER, 8'h01, METH_NOAUTH, 8'h04};
    send(seq);
    // nothing acceptable, unsupported command
    seq = '{SOCKS_VER, 8'h02, 8'h01, 8'hFF, SOCKS_VER, 8'h02};
    send(seq);
    // reserved byte not zero
    seq = '{SOCKS_VER, 8'h01, 8'h80, SOCKS_VER, CMD_CONNECT, 8'h01};
    send(seq);
    // unknown address type
    seq = '{SOCKS_VER, 8'h01, METH_NOAUTH, SOCKS_VER, CMD_CONNECT, BYTE_ZERO, 8'h02};
    send(seq);
    // empty domain, max port, trailing byte ignored after done
    seq = '{SOCKS_VER, 8'h01, METH_NOAUTH, SOCKS_VER, CMD_CONNECT, BYTE_ZERO,
            ATYP_DOMAIN, 8'h00, 8'hFF, 8'hFF, 8'h00};
    send(seq);
    directed = pending_bytes.size();

    while (pending_bytes.size() < directed + 1600) begin
      pick = $urandom_range(0, 99);
      seq  = build_handshake();
      if (pick < 70) begin
        send(seq);
        repeat ($urandom_range(0, 2)) begin
          it.data_byte = 8'($urandom);
          it.restart   = 1'b0;
          pending_bytes.push_back(it);
        end
      end else if (pick < 92) begin
        // corrupt and/or cut the request at a random point
        cut = $urandom_range(0, seq.size() - 1);
        if ($urandom_range(0, 1)) seq[cut] = 8'($urandom);
        if ($urandom_range(0, 1)) begin
          while (seq.size() > cut + 1) void'(seq.pop_back());
        end
        send(seq);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          it.data_byte = 8'($urandom);
          it.restart   = ($urandom_range(0, 3) == 0);
          pending_bytes.push_back(it);
        end
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("socks5_handshake_parser verification clean");
    end else begin
      $display("socks5_handshake_parser verification failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("socks5_handshake_parser verification failed");
    $finish;
  end

endmodule
